// File: hdl/mevq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mevq_pkg
// Shared types, constants and helpers of the pointer event queue.
// ----------------------------------------------------------------------------
package mevq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int FILL_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int COORD_W     = 16;
  localparam int BTN_W       = 3;

  typedef logic [PTR_W-1:0]   ptr_t;
  typedef logic [FILL_W-1:0]  fill_t;
  typedef logic [COORD_W-1:0] coord_t;
  typedef logic [BTN_W-1:0]   btn_t;

  typedef enum logic [1:0] {
    MODE_POLL    = 2'd0,
    MODE_DEQUEUE = 2'd1,
    MODE_LAST    = 2'd2,
    MODE_NOP     = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    KIND_MOVED = 2'd0,
    KIND_LEFT  = 2'd1,
    KIND_RIGHT = 2'd2,
    KIND_OTHER = 2'd3
  } kind_t;

  localparam btn_t BTN_LEFT_ONLY  = 3'd1;
  localparam btn_t BTN_RIGHT_ONLY = 3'd2;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_READ = 1'b1
  } state_t;

  typedef struct packed {
    kind_t  kind;
    coord_t x;
    coord_t y;
    btn_t   buttons;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    coord_t x;
    coord_t y;
    btn_t   buttons;
  } sample_t;

  typedef struct packed {
    logic  produce;
    kind_t kind;
  } det_t;

  typedef struct packed {
    logic   event_valid;
    kind_t  event_kind;
    coord_t x;
    coord_t y;
    btn_t   buttons;
    logic   queued;
    logic   dropped;
  } result_t;

  function automatic ptr_t ptr_advance(ptr_t p);
    ptr_t q;
    if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
      q = '0;
    end else begin
      q = p + ptr_t'(1);
    end
    return q;
  endfunction

endpackage
`default_nettype wire

// File: hdl/mevq_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mevq_ram
// Simple dual-port memory, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module mevq_ram #(
  parameter int DEPTH  = 16,
  parameter int WIDTH  = 37,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]  wr_data,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output logic      [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

// File: hdl/mevq_detect.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mevq_detect
// Change detector: compares a polled sample with the recorded one and
// classifies the event.
// ----------------------------------------------------------------------------
module mevq_detect
  import mevq_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    poll,
  input  wire sample_t sample,
  output det_t         det
);

  coord_t prev_x_r;
  coord_t prev_y_r;
  btn_t   prev_buttons_r;

  always_comb begin
    det.produce = 1'b0;
    det.kind    = KIND_MOVED;
    priority if (sample.x != prev_x_r || sample.y != prev_y_r) begin
      det.produce = 1'b1;
      det.kind    = KIND_MOVED;
    end else if (sample.buttons != prev_buttons_r) begin
      det.produce = 1'b1;
      priority if (sample.buttons == BTN_LEFT_ONLY) begin
        det.kind = KIND_LEFT;
      end else if (sample.buttons == BTN_RIGHT_ONLY) begin
        det.kind = KIND_RIGHT;
      end else begin
        det.kind = KIND_OTHER;
      end
    end else begin
      det.produce = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_x_r       <= '0;
      prev_y_r       <= '0;
      prev_buttons_r <= '0;
    end else if (poll && det.produce) begin
      prev_x_r       <= sample.x;
      prev_y_r       <= sample.y;
      prev_buttons_r <= sample.buttons;
    end
  end

`ifndef NO_ASSERTIONS
  a_produce_on_change: assert property (@(posedge clk) disable iff (!rst_n)
    (sample.x != prev_x_r) |-> det.produce)
    else $error("position change not detected");

  a_record_sample: assert property (@(posedge clk) disable iff (!rst_n)
    (poll && det.produce) |=> (prev_x_r == $past(sample.x) && prev_y_r == $past(sample.y)
                               && prev_buttons_r == $past(sample.buttons)))
    else $error("sample not recorded");

  a_kind_moved: assert property (@(posedge clk) disable iff (!rst_n)
    (det.produce && det.kind != KIND_MOVED) |-> (sample.x == prev_x_r && sample.y == prev_y_r))
    else $error("button kind with moved position");
`endif

endmodule
`default_nettype wire

// File: hdl/mouse_event_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mouse_event_queue
// Pointer event queue with change detection.
//
// Input words carry a mode in in_tuser and a pointer sample in in_tdata.
// A poll compares the sample with the recorded one and queues a moved,
// left, right or other-button event in a ring of QUEUE_DEPTH entries; a
// full ring drops the event and flags it. A dequeue returns the oldest
// event, a read-last returns the sample of the last dequeued event.
// Every accepted word yields exactly one result word.
// Timing: poll, read-last, empty dequeue and the unused mode give their
// result in the cycle after acceptance; a dequeue from a non-empty ring
// gives it after the ST_READ state, set by the registered read of the event
// memory. Throughput: one word per cycle while out_tready is high, except
// that a non-empty dequeue holds the input during ST_READ.
// Reset empties the ring and clears the recorded and last samples; the
// memory contents stay as they are and need no clearing pass.
// A stalled out_tready holds the result register and deasserts in_tready.
// ----------------------------------------------------------------------------
module mouse_event_queue
  import mevq_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [39:0] in_tdata,   // sample_x, sample_y, sample_buttons, zero pad
  input  wire logic [1:0]  in_tuser,   // mode
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [39:0] out_tdata,  // out_x, out_y, out_buttons, queued, dropped, zero pad
  output logic      [2:0]  out_tuser   // event_valid, event_kind
);

  state_t  state_r,  state_nxt;
  ptr_t    wr_ptr_r, wr_ptr_nxt;
  ptr_t    rd_ptr_r, rd_ptr_nxt;
  fill_t   fill_r,   fill_nxt;
  sample_t last_r,   last_nxt;
  logic    out_valid_r, out_valid_nxt;
  result_t res_r,    res_nxt;

  logic    in_acc;
  mode_t   mode;
  sample_t sample;
  det_t    det;
  logic    full;
  logic    empty;
  logic    ram_we;
  logic    ram_re;
  entry_t  wr_entry;
  logic [ENTRY_W-1:0] rd_bits;
  entry_t  rd_entry;

  assign mode           = mode_t'(in_tuser);
  assign sample.x       = in_tdata[15:0];
  assign sample.y       = in_tdata[31:16];
  assign sample.buttons = in_tdata[34:32];
  assign in_acc         = in_tvalid && in_tready;
  assign full           = (fill_r == FILL_W'(QUEUE_DEPTH));
  assign empty          = (fill_r == '0);
  assign rd_entry       = entry_t'(rd_bits);

  assign wr_entry.kind    = det.kind;
  assign wr_entry.x       = sample.x;
  assign wr_entry.y       = sample.y;
  assign wr_entry.buttons = sample.buttons;

  mevq_detect u_detect (
    .clk    (clk),
    .rst_n  (rst_n),
    .poll   (in_acc && mode == MODE_POLL),
    .sample (sample),
    .det    (det)
  );

  mevq_ram #(
    .DEPTH (QUEUE_DEPTH),
    .WIDTH (ENTRY_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (wr_ptr_r),
    .wr_data (wr_entry),
    .rd_en   (ram_re),
    .rd_addr (rd_ptr_r),
    .rd_data (rd_bits)
  );

  always_comb begin
    in_tready     = (state_r == ST_IDLE) && (!out_valid_r || out_tready);
    state_nxt     = state_r;
    wr_ptr_nxt    = wr_ptr_r;
    rd_ptr_nxt    = rd_ptr_r;
    fill_nxt      = fill_r;
    last_nxt      = last_r;
    out_valid_nxt = out_valid_r && !out_tready;
    res_nxt       = res_r;
    ram_we        = 1'b0;
    ram_re        = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          res_nxt = '0;
          unique case (mode)
            MODE_POLL: begin
              out_valid_nxt      = 1'b1;
              res_nxt.event_kind = det.kind;
              if (det.produce) begin
                if (full) begin
                  res_nxt.dropped = 1'b1;
                end else begin
                  ram_we         = 1'b1;
                  wr_ptr_nxt     = ptr_advance(wr_ptr_r);
                  fill_nxt       = fill_r + fill_t'(1);
                  res_nxt.queued = 1'b1;
                end
              end
            end
            MODE_DEQUEUE: begin
              if (empty) begin
                out_valid_nxt = 1'b1;
              end else begin
                ram_re     = 1'b1;
                rd_ptr_nxt = ptr_advance(rd_ptr_r);
                fill_nxt   = fill_r - fill_t'(1);
                state_nxt  = ST_READ;
              end
            end
            MODE_LAST: begin
              out_valid_nxt   = 1'b1;
              res_nxt.x       = last_r.x;
              res_nxt.y       = last_r.y;
              res_nxt.buttons = last_r.buttons;
            end
            MODE_NOP: begin
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end
      ST_READ: begin
        out_valid_nxt       = 1'b1;
        res_nxt             = '0;
        res_nxt.event_valid = 1'b1;
        res_nxt.event_kind  = rd_entry.kind;
        res_nxt.x           = rd_entry.x;
        res_nxt.y           = rd_entry.y;
        res_nxt.buttons     = rd_entry.buttons;
        last_nxt.x          = rd_entry.x;
        last_nxt.y          = rd_entry.y;
        last_nxt.buttons    = rd_entry.buttons;
        state_nxt           = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      wr_ptr_r    <= '0;
      rd_ptr_r    <= '0;
      fill_r      <= '0;
      last_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wr_ptr_r    <= wr_ptr_nxt;
      rd_ptr_r    <= rd_ptr_nxt;
      fill_r      <= fill_nxt;
      last_r      <= last_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = {res_r.event_kind, res_r.event_valid};
  assign out_tdata  = {3'b000, res_r.dropped, res_r.queued, res_r.buttons, res_r.y, res_r.x};

`ifndef NO_ASSERTIONS
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FILL_W'(QUEUE_DEPTH))
    else $error("fill count beyond queue depth");

  a_ptr_match: assert property (@(posedge clk) disable iff (!rst_n)
    (empty || full) |-> (wr_ptr_r == rd_ptr_r))
    else $error("pointers disagree with fill count");

  a_read_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && mode == MODE_DEQUEUE && !empty) |=> (state_r == ST_READ && !in_tready))
    else $error("dequeue did not enter memory read");

  a_drop_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && res_r.dropped) |-> full)
    else $error("event dropped without full queue");

  a_read_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_READ) |=> (out_valid_r && res_r.event_valid))
    else $error("memory read gave no result");
`endif

endmodule
`default_nettype wire
